/* hdl/ede_pkg.sv */
// shared constants, opcodes and the wavefront beat type of the edit distance engine
// no dependencies; compile first
package ede_pkg;

  localparam int MAX_LEN = 64;
  localparam int SYM_W   = 8;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int COST_W  = 7;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STREAM = 2'd1,
    OP_FINISH = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  // one beat of the wavefront passed from a cell to its right neighbor
  typedef struct packed {
    logic              valid;
    logic [SYM_W-1:0]  symbol;
    logic [COST_W-1:0] left;
    logic [COST_W-1:0] diag;
  } wave_t;

endpackage

/* hdl/ede_if.sv */
// valid/ready channel interfaces for the request and result sides
// depends on ede_pkg
interface ede_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [ede_pkg::SYM_W-1:0] symbol;

  modport source (output valid, output opcode, output symbol, input ready);
  modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

interface ede_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ede_pkg::COST_W-1:0] distance;
  logic                       overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink   (input valid, input distance, input overflow, output ready);
endinterface

/* hdl/ede_cell.sv */
// one cell of the systolic row: holds one first-word symbol and one cost entry
// depends on ede_pkg
module ede_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ede_pkg::COST_W-1:0] init_cost,
  input  logic                       load_en,
  input  logic [ede_pkg::SYM_W-1:0]  load_symbol,
  input  logic                       clear,
  input  ede_pkg::wave_t             wave_in,
  output ede_pkg::wave_t             wave_out
);

  logic [ede_pkg::SYM_W-1:0]  symbol;
  logic                       active;
  logic [ede_pkg::COST_W-1:0] cost;
  logic [ede_pkg::COST_W-1:0] cost_next;
  logic [ede_pkg::COST_W-1:0] min_ab;
  logic [ede_pkg::COST_W-1:0] min_abc;

  always_comb begin
    min_ab  = (wave_in.diag < cost) ? wave_in.diag : cost;
    min_abc = (min_ab < wave_in.left) ? min_ab : wave_in.left;
    if (!active) begin
      // past the end of the first word: carry the left value on
      cost_next = wave_in.left;
    end else if (symbol == wave_in.symbol) begin
      cost_next = wave_in.diag;
    end else begin
      cost_next = min_abc + ede_pkg::COST_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      active <= 1'b0;
      cost   <= init_cost;
    end else begin
      if (load_en) active <= 1'b1;
      if (wave_in.valid) cost <= cost_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) symbol <= load_symbol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out.valid <= 1'b0;
    end else begin
      wave_out.valid <= wave_in.valid;
    end
    wave_out.symbol <= wave_in.symbol;
    wave_out.left   <= cost_next;
    wave_out.diag   <= cost;
  end

endmodule

/* hdl/edit_distance_engine_core.sv */
// top level of the edit distance engine: command decode, the row of cells,
// drain timer and result register; depends on ede_pkg, ede_if and ede_cell
//
// usage
//   req channel: one beat per command. opcode load appends symbol to the first
//   word, stream feeds the next symbol of the second word, finish asks for the
//   result. symbol is ignored on finish; opcode 3 is taken and does nothing.
//   rsp channel: one beat per finish carrying distance and overflow.
// throughput
//   load and stream beats are taken one per cycle, back to back, outside a drain. a stream beat
//   enters the first cell and moves one cell to the right per cycle along the row
//   of MAX_LEN cells, so consecutive streams overlap as a skewed wavefront.
// drain
//   after a finish beat req.ready drops while the wavefront drains: the result
//   is registered once the drain timer, sized by the length of the cell row, has
//   run out and rsp is free. ready returns at the edge that writes the result.
// reset
//   rst clears lengths, the overflow flag, the cost row (entry k holds k) and
//   all valid bits; no clearing pass is needed. first-word symbols are not
//   cleared and are only used once loaded.
// stall
//   the result sits in rsp until taken; loads and streams are still taken
//   meanwhile. a second finish waits in the drain state until rsp is free.
module edit_distance_engine_core (
  input logic       clk,
  input logic       rst,
  ede_req_if.sink   req,
  ede_rsp_if.source rsp
);

  localparam int N = ede_pkg::MAX_LEN;

  ede_pkg::state_t            state;
  logic [ede_pkg::LEN_W-1:0]  first_length;
  logic [ede_pkg::LEN_W-1:0]  second_length;
  logic                       overflow_seen;
  logic [ede_pkg::CNT_W-1:0]  drain_cnt;

  ede_pkg::wave_t             wave [N+1];

  logic                       accept;
  logic                       do_load;
  logic                       do_stream;
  logic                       emit;

  assign req.ready = (state == ede_pkg::ST_RUN);
  assign accept    = req.valid && req.ready;

  // loads are only taken before any stream and while the store has room
  assign do_load   = accept && (req.opcode == ede_pkg::OP_LOAD) &&
                     (second_length == '0) &&
                     (first_length < ede_pkg::LEN_W'(N));
  assign do_stream = accept && (req.opcode == ede_pkg::OP_STREAM) &&
                     (second_length < ede_pkg::LEN_W'(N));

  // result goes out once the wavefront has left the last cell and rsp is free
  assign emit = (state == ede_pkg::ST_DRAIN) && (drain_cnt == '0) &&
                (!rsp.valid || rsp.ready);

  // control: lengths, overflow flag, drain state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ede_pkg::ST_RUN;
      first_length  <= '0;
      second_length <= '0;
      overflow_seen <= 1'b0;
      drain_cnt     <= '0;
    end else begin
      case (state)
        ede_pkg::ST_RUN: begin
          if (do_load) first_length <= first_length + ede_pkg::LEN_W'(1);
          if (do_stream) second_length <= second_length + ede_pkg::LEN_W'(1);
          // word too long: symbol dropped and flagged
          if (accept && (req.opcode == ede_pkg::OP_LOAD) && (second_length == '0) &&
              (first_length >= ede_pkg::LEN_W'(N))) begin
            overflow_seen <= 1'b1;
          end
          if (accept && (req.opcode == ede_pkg::OP_STREAM) &&
              (second_length >= ede_pkg::LEN_W'(N))) begin
            overflow_seen <= 1'b1;
          end
          if (accept && (req.opcode == ede_pkg::OP_FINISH)) begin
            state     <= ede_pkg::ST_DRAIN;
            drain_cnt <= ede_pkg::CNT_W'(N);
          end
        end
        ede_pkg::ST_DRAIN: begin
          if (drain_cnt != '0) drain_cnt <= drain_cnt - ede_pkg::CNT_W'(1);
          if (emit) begin
            state         <= ede_pkg::ST_RUN;
            first_length  <= '0;
            second_length <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: begin
          state <= ede_pkg::ST_RUN;
        end
      endcase
    end
  end

  // injection stage: cost_row[0] becomes second_length + 1, old value is the diagonal
  always_ff @(posedge clk) begin
    if (rst) begin
      wave[0].valid <= 1'b0;
    end else begin
      wave[0].valid <= do_stream;
    end
    wave[0].symbol <= req.symbol;
    wave[0].left   <= ede_pkg::COST_W'(second_length) + ede_pkg::COST_W'(1);
    wave[0].diag   <= ede_pkg::COST_W'(second_length);
  end

  // the row of cells; cell i holds first_word[i] and cost_row[i+1]
  for (genvar i = 0; i < N; i++) begin : g_cell
    ede_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .init_cost   (ede_pkg::COST_W'(i + 1)),
      .load_en     (do_load && (first_length == ede_pkg::LEN_W'(i))),
      .load_symbol (req.symbol),
      .clear       (emit),
      .wave_in     (wave[i]),
      .wave_out    (wave[i+1])
    );
  end

  // result register; cells past the first word copy their left value, so the
  // last cell ends up with cost_row[first_length]. its held cost shows up one
  // stage later as the diagonal, which stays put once the wavefront is gone
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (emit) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      // empty second word: distance is the first word's length
      rsp.distance <= (second_length == '0) ? ede_pkg::COST_W'(first_length)
                                            : wave[N].diag;
      rsp.overflow <= overflow_seen;
    end
  end

endmodule

/* hdl/ede_checker.sv */
// port-level checks for edit_distance_engine_core, attached by bind
// depends on ede_pkg
module ede_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic [1:0]                 req_opcode,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [ede_pkg::COST_W-1:0] rsp_distance
);

  // result held until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_distance))
    else $error("result beat dropped or changed while stalled");

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  // a finish stops intake while the row drains
  a_finish_blocks: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_opcode == ede_pkg::OP_FINISH) |=> !req_ready)
    else $error("intake open during drain");

  // distance never exceeds the longest word the row can hold
  a_dist_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_distance <= ede_pkg::COST_W'(ede_pkg::MAX_LEN)))
    else $error("distance out of range");

endmodule

bind edit_distance_engine_core ede_checker u_ede_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .req_opcode   (req.opcode),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .rsp_distance (rsp.distance)
);

/* tb/edit_distance_engine_core_tb.sv */
`timescale 1ns / 100ps
// testbench of edit_distance_engine_core: directed table, then random word pairs checked by
// a row-by-row edit distance predictor; depends on ede_pkg, ede_if and the engine rtl
module edit_distance_engine_core_tb;
  import ede_pkg::*;

  // opcode 3 is taken by the engine and does nothing
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_BEATS = 1000;
  localparam int IDLE_PCT     = 37;
  localparam int HOLD_CYCLES  = 500;
  localparam int LIMIT_NS     = 1_000_000;

  typedef struct packed {
    logic [COST_W-1:0] distance;
    logic              overflow;
  } edit_result_t;

  // one directed row: a command repeated, and where typed the result that it must give
  typedef struct packed {
    logic [1:0]        opcode;
    logic [SYM_W-1:0]  symbol;
    logic [7:0]        repeats;
    logic              typed;
    logic [COST_W-1:0] distance;
    logic              overflow;
  } stim_row_t;

  localparam int NUM_ROWS = 23;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // finish straight after reset: both words empty
    '{OP_FINISH, 8'h00,  8'd1, 1'b1,  7'd0, 1'b0},
    // unused opcode leaves everything alone
    '{OP_UNUSED, 8'hFF,  8'd1, 1'b0,  7'd0, 1'b0},
    '{OP_FINISH, 8'h00,  8'd1, 1'b1,  7'd0, 1'b0},
    // empty second word gives the first word's length
    '{OP_LOAD,   8'h61,  8'd3, 1'b0,  7'd0, 1'b0},
    '{OP_FINISH, 8'h00,  8'd1, 1'b1,  7'd3, 1'b0},
    // empty first word gives the second word's length; symbol ignored on finish
    '{OP_STREAM, 8'h00,  8'd5, 1'b0,  7'd0, 1'b0},
    '{OP_FINISH, 8'hFF,  8'd1, 1'b1,  7'd5, 1'b0},
    // symbol extremes, swapped order, and a load after streaming that is dropped
    '{OP_LOAD,   8'h00,  8'd1, 1'b0,  7'd0, 1'b0},
    '{OP_LOAD,   8'hFF,  8'd1, 1'b0,  7'd0, 1'b0},
    '{OP_STREAM, 8'hFF,  8'd1, 1'b0,  7'd0, 1'b0},
    '{OP_STREAM, 8'h00,  8'd1, 1'b0,  7'd0, 1'b0},
    '{OP_LOAD,   8'h55,  8'd1, 1'b0,  7'd0, 1'b0},
    '{OP_FINISH, 8'h00,  8'd1, 1'b0,  7'd0, 1'b0},
    // both words at full length and equal
    '{OP_LOAD,   8'hAA, 8'd64, 1'b0,  7'd0, 1'b0},
    '{OP_STREAM, 8'hAA, 8'd64, 1'b0,  7'd0, 1'b0},
    '{OP_FINISH, 8'h00,  8'd1, 1'b1,  7'd0, 1'b0},
    // first word too long
    '{OP_LOAD,   8'h01, 8'd65, 1'b0,  7'd0, 1'b0},
    '{OP_FINISH, 8'h00,  8'd1, 1'b1, 7'd64, 1'b1},
    // second word too long
    '{OP_STREAM, 8'hFE, 8'd66, 1'b0,  7'd0, 1'b0},
    '{OP_FINISH, 8'h00,  8'd1, 1'b1, 7'd64, 1'b1},
    // largest distance: every symbol replaced
    '{OP_LOAD,   8'h12, 8'd64, 1'b0,  7'd0, 1'b0},
    '{OP_STREAM, 8'h34, 8'd64, 1'b0,  7'd0, 1'b0},
    '{OP_FINISH, 8'h00,  8'd1, 1'b1, 7'd64, 1'b0}
  };

  logic clk;
  logic rst;

  ede_req_if req_ch ();
  ede_rsp_if rsp_ch ();

  edit_distance_engine_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // predictor state: stored first word, lengths and the current dp row
  logic [SYM_W-1:0] pred_first_word [MAX_LEN];
  int               pred_first_len;
  int               pred_second_len;
  int               pred_cost_row [MAX_LEN+1];
  bit               pred_overflow;

  edit_result_t pending_results [$];
  edit_result_t oldest_result;

  int mismatches;
  int effective_beats;   // counted only in the random part
  bit random_phase;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout with %0d results still pending", pending_results.size());
    $display("status: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // lengths, overflow flag and the dp row back to their idle values
  function automatic void clear_distance_state();
    pred_first_len  = 0;
    pred_second_len = 0;
    pred_overflow   = 1'b0;
    for (int k = 0; k <= MAX_LEN; k++) pred_cost_row[k] = k;
  endfunction

  // applies one accepted command to the predictor; returns 0 when the command is ignored
  function automatic bit predict_edit_step(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                                           output bit emits, output edit_result_t res);
    int diag;
    int above;
    int best;
    bit took;
    emits = 1'b0;
    res   = '0;
    took  = 1'b1;
    case (op)
      OP_LOAD: begin
        // loads are only taken before the second word starts
        if (pred_second_len != 0) took = 1'b0;
        else if (pred_first_len >= MAX_LEN) pred_overflow = 1'b1;
        else begin
          pred_first_word[pred_first_len] = sym;
          pred_first_len++;
        end
      end
      OP_STREAM: begin
        if (pred_second_len >= MAX_LEN) pred_overflow = 1'b1;
        else begin
          // prefix recurrence: one new row per second-word symbol
          diag = pred_cost_row[0];
          pred_cost_row[0] = pred_second_len + 1;
          for (int k = 1; k <= pred_first_len; k++) begin
            above = pred_cost_row[k];
            if (pred_first_word[k-1] == sym) pred_cost_row[k] = diag;
            else begin
              best = diag < above ? diag : above;
              best = best < pred_cost_row[k-1] ? best : pred_cost_row[k-1];
              pred_cost_row[k] = best + 1;
            end
            diag = above;
          end
          pred_second_len++;
        end
      end
      OP_FINISH: begin
        emits        = 1'b1;
        res.distance = pred_cost_row[pred_first_len][COST_W-1:0];
        res.overflow = pred_overflow;
        clear_distance_state();
      end
      default: took = 1'b0;
    endcase
    return took;
  endfunction

  // offers one command beat, idling first at random, and records what it must give
  task automatic send_command(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                              input bit typed, input edit_result_t typed_res);
    bit           emits;
    bit           took;
    bit           calm;
    edit_result_t res;
    calm = random_phase && effective_beats >= 300 && effective_beats < 600;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      // valid drops here and only comes back at a later edge
      req_ch.valid  <= 1'b0;
      req_ch.opcode <= 2'($urandom);
      req_ch.symbol <= SYM_W'($urandom);
      @(posedge clk);
      while ($urandom_range(0, 99) < IDLE_PCT) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.opcode <= op;
    req_ch.symbol <= sym;
    do @(posedge clk); while (!req_ch.ready);
    // beat taken at this edge
    took = predict_edit_step(op, sym, emits, res);
    if (emits) pending_results.push_back(typed ? typed_res : res);
    if (took && random_phase) effective_beats++;
  endtask

  // word lengths: mostly short, some long, a few near or past the store size
  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 8);
    if (r < 95) return $urandom_range(9, 63);
    return $urandom_range(60, 70);
  endfunction

  // a narrow alphabet makes matches common; a wide one covers every symbol bit
  function automatic logic [SYM_W-1:0] pick_symbol(input bit narrow, input logic [SYM_W-1:0] base);
    if (narrow) return base + SYM_W'($urandom_range(0, 3));
    return SYM_W'($urandom);
  endfunction

  // result side: random back-pressure, a calm window and one long hold-off
  initial begin : result_side
    int cycle_no;
    int hold_left;
    bit held_once;
    cycle_no  = 0;
    hold_left = 0;
    held_once = 1'b0;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      cycle_no++;
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!held_once && random_phase && effective_beats >= 150) begin
        // results pile up, a second finish waits in drain and the request side stalls
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
        rsp_ch.ready <= 1'b0;
      end else if (cycle_no >= 400 && cycle_no < 1400) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // every result beat against the oldest pending expectation
  always @(posedge clk) begin
    if (rst === 1'b0 && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result beat, distance", rsp_ch.distance, -1);
      end else begin
        oldest_result = pending_results.pop_front();
        if (rsp_ch.distance !== oldest_result.distance)
          report_mismatch("distance", rsp_ch.distance, oldest_result.distance);
        if (rsp_ch.overflow !== oldest_result.overflow)
          report_mismatch("overflow", rsp_ch.overflow, oldest_result.overflow);
      end
    end
  end

  initial begin : request_side
    stim_row_t        row;
    edit_result_t     row_res;
    int               kind;
    int               len_a;
    int               len_b;
    bit               narrow;
    logic [SYM_W-1:0] base;
    mismatches      = 0;
    effective_beats = 0;
    random_phase    = 1'b0;
    clear_distance_state();
    rst           <= 1'b1;
    req_ch.valid  <= 1'b0;
    req_ch.opcode <= OP_LOAD;
    req_ch.symbol <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      row = DIRECTED_ROWS[r];
      row_res.distance = row.distance;
      row_res.overflow = row.overflow;
      repeat (row.repeats) send_command(row.opcode, row.symbol, row.typed, row_res);
    end

    // random word pairs with some noise and broken sequences
    random_phase = 1'b1;
    while (effective_beats < RANDOM_BEATS) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        repeat ($urandom_range(1, 8))
          send_command(2'($urandom_range(0, 3)), SYM_W'($urandom), 1'b0, '0);
      end else begin
        len_a  = pick_length();
        len_b  = pick_length();
        narrow = $urandom_range(0, 99) < 70;
        base   = SYM_W'($urandom);
        repeat (len_a) send_command(OP_LOAD, pick_symbol(narrow, base), 1'b0, '0);
        repeat (len_b) begin
          send_command(OP_STREAM, pick_symbol(narrow, base), 1'b0, '0);
          // now and then a stray load in the middle of the second word
          if ($urandom_range(0, 99) < 3) send_command(OP_LOAD, SYM_W'($urandom), 1'b0, '0);
        end
        send_command(OP_FINISH, SYM_W'($urandom), 1'b0, '0);
      end
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // let the wavefront drain past the row length
    repeat (MAX_LEN + 8) @(posedge clk);
    if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
